// ----- src/ocp_pkg.sv -----
// ----------------------------------------------------------------------------
// ocp_pkg
// Shared types, constants and coordinate helpers for the outline to cubic
// path converter.
// ----------------------------------------------------------------------------
package ocp_pkg;

    // field widths
    localparam int W_IN  = 24;  // outline point, wrap point and origin fields
    localparam int W_ST  = 26;  // held coordinate, in units of three output units
    localparam int W_OUT = 32;  // result coordinate

    // result queue, depth must be a power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef logic signed [W_IN-1:0]  t_in_coord;
    typedef logic signed [W_ST-1:0]  t_coord;
    typedef logic signed [W_OUT-1:0] t_word;

    // point tags
    localparam logic [1:0] TAG_CONIC = 2'd0;
    localparam logic [1:0] TAG_CUBIC = 2'd2;

    // pending count: one more than the number of pending points
    localparam logic [1:0] PC_ONE   = 2'd1;
    localparam logic [1:0] PC_TWO   = 2'd2;
    localparam logic [1:0] PC_THREE = 2'd3;

    // path command kinds
    typedef enum logic [1:0] {
        KIND_MOVE  = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_CUBIC = 2'd2,
        KIND_CLOSE = 2'd3
    } t_kind;

    typedef struct packed {
        t_in_coord  point_x;
        t_in_coord  point_y;
        logic [1:0] tag;
        logic       contour_first;
        logic       contour_last;
        t_in_coord  wrap_x;
        t_in_coord  wrap_y;
        t_in_coord  origin_x;
        t_in_coord  origin_y;
    } t_item;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // converter state, coordinates held in units of three
    typedef struct packed {
        t_point     start;
        t_point     c0;      // current pen point
        t_point     c1;      // first pending point
        t_point     c2;      // second pending point
        logic [1:0] pc;
    } t_state;

    // converter state after reset: pen and start at (0,0), nothing pending
    localparam t_state ST_RESET = '{start: '0, c0: '0, c1: '0, c2: '0, pc: PC_ONE};

    typedef struct packed {
        t_kind kind;
        t_word p1_x;
        t_word p1_y;
        t_word p2_x;
        t_word p2_y;
        t_word p3_x;
        t_word p3_y;
        logic  last_of_run;
    } t_result;

    // results handed to the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // held coordinate to output units: times three
    function automatic t_word f_act(input t_coord a);
        t_word v;
        v = W_OUT'(a);
        return (v <<< 1) + v;
    endfunction

    // degree raising term 2a + b, in output units
    function automatic t_word f_raise(input t_coord a, input t_coord b);
        return (W_OUT'(a) <<< 1) + W_OUT'(b);
    endfunction

    // midpoint of two even held coordinates, exact
    function automatic t_coord f_mid(input t_coord a, input t_coord b);
        logic signed [W_ST:0] s;
        s = (W_ST+1)'(a) + (W_ST+1)'(b);
        return s[W_ST:1];
    endfunction

    function automatic t_result f_cmd(input t_kind k,
                                      input t_word a, input t_word b,
                                      input t_word c, input t_word d,
                                      input t_word e, input t_word f);
        t_result r;
        r.kind        = k;
        r.p1_x        = a;
        r.p1_y        = b;
        r.p2_x        = c;
        r.p2_y        = d;
        r.p3_x        = e;
        r.p3_y        = f;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

// ----- src/ocp_point_if.sv -----
// ----------------------------------------------------------------------------
// ocp_point_if
// Outline point channel: valid/ready handshake with one outline point word.
// ----------------------------------------------------------------------------
interface ocp_point_if
    import ocp_pkg::*;
();
    logic       valid;
    logic       ready;
    t_in_coord  point_x;
    t_in_coord  point_y;
    logic [1:0] tag;
    logic       contour_first;
    logic       contour_last;
    t_in_coord  wrap_x;
    t_in_coord  wrap_y;
    t_in_coord  origin_x;
    t_in_coord  origin_y;

    modport source (
        output valid, point_x, point_y, tag, contour_first, contour_last,
               wrap_x, wrap_y, origin_x, origin_y,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, tag, contour_first, contour_last,
               wrap_x, wrap_y, origin_x, origin_y,
        output ready
    );
endinterface

// ----- src/ocp_cmd_if.sv -----
// ----------------------------------------------------------------------------
// ocp_cmd_if
// Path command channel: valid/ready handshake with one command word.
// ----------------------------------------------------------------------------
interface ocp_cmd_if
    import ocp_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    t_word      p1_x;
    t_word      p1_y;
    t_word      p2_x;
    t_word      p2_y;
    t_word      p3_x;
    t_word      p3_y;
    logic       last_of_run;

    modport source (
        output valid, kind, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, kind, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, last_of_run,
        output ready
    );
endinterface

// ----- src/ocp_step.sv -----
// ----------------------------------------------------------------------------
// ocp_step
// Single pass conversion of one outline point: next converter state and up
// to two path commands (body command, then contour close).
// ----------------------------------------------------------------------------
module ocp_step
    import ocp_pkg::*;
(
    input  t_item  i_item,
    input  t_state i_state,
    output t_state o_state,
    output t_push  o_push
);

    t_coord  qx, qy, qwx, qwy;
    t_point  p, s0, mid;
    t_state  st;
    t_result res_a, res_b;
    logic    has_a, has_b;
    logic    on_curve;

    // point mapped to units of three: 2 * (origin + x), 2 * (origin - y)
    assign qx  = W_ST'(i_item.origin_x) + W_ST'(i_item.point_x);
    assign qy  = W_ST'(i_item.origin_y) - W_ST'(i_item.point_y);
    assign qwx = W_ST'(i_item.origin_x) + W_ST'(i_item.wrap_x);
    assign qwy = W_ST'(i_item.origin_y) - W_ST'(i_item.wrap_y);
    assign p.x = qx <<< 1;
    assign p.y = qy <<< 1;

    // contour start, averaged with the wrap point when off-curve
    assign on_curve = i_item.tag[0];
    assign s0.x     = on_curve ? p.x : qx + qwx;
    assign s0.y     = on_curve ? p.y : qy + qwy;

    // body of the point
    always_comb begin
        st    = i_state;
        has_a = 1'b0;
        res_a = '0;
        mid   = '0;
        if (i_item.contour_first) begin
            st.start = s0;
            st.c0    = s0;
            st.pc    = PC_ONE;
            has_a    = 1'b1;
            res_a    = f_cmd(KIND_MOVE, f_act(s0.x), f_act(s0.y), '0, '0, '0, '0);
        end else begin
            case (i_state.pc)
                PC_TWO: begin
                    st.c2 = p;
                    if (i_item.tag == TAG_CUBIC) begin
                        st.pc = PC_THREE;
                    end else if (i_item.tag == TAG_CONIC) begin
                        mid.x = f_mid(i_state.c1.x, p.x);
                        mid.y = f_mid(i_state.c1.y, p.y);
                        has_a = 1'b1;
                        res_a = f_cmd(KIND_CUBIC,
                                      f_raise(i_state.c1.x, i_state.c0.x),
                                      f_raise(i_state.c1.y, i_state.c0.y),
                                      f_raise(i_state.c1.x, mid.x),
                                      f_raise(i_state.c1.y, mid.y),
                                      f_act(mid.x), f_act(mid.y));
                        st.c0 = mid;
                        st.c1 = p;
                        st.pc = PC_TWO;
                    end else begin
                        has_a = 1'b1;
                        res_a = f_cmd(KIND_CUBIC,
                                      f_raise(i_state.c1.x, i_state.c0.x),
                                      f_raise(i_state.c1.y, i_state.c0.y),
                                      f_raise(i_state.c1.x, p.x),
                                      f_raise(i_state.c1.y, p.y),
                                      f_act(p.x), f_act(p.y));
                        st.c0 = p;
                        st.pc = PC_ONE;
                    end
                end
                PC_THREE: begin
                    has_a = 1'b1;
                    if (i_item.tag == TAG_CUBIC) begin
                        // midpoint of the last two cubic controls ends a cubic
                        mid.x = f_mid(i_state.c2.x, p.x);
                        mid.y = f_mid(i_state.c2.y, p.y);
                        res_a = f_cmd(KIND_CUBIC,
                                      f_act(i_state.c1.x), f_act(i_state.c1.y),
                                      f_act(i_state.c2.x), f_act(i_state.c2.y),
                                      f_act(mid.x), f_act(mid.y));
                        st.c0 = mid;
                        st.c1 = p;
                        st.pc = PC_TWO;
                    end else if (i_item.tag == TAG_CONIC) begin
                        // first two pending points raised as a quadratic
                        mid.x = f_mid(i_state.c1.x, i_state.c2.x);
                        mid.y = f_mid(i_state.c1.y, i_state.c2.y);
                        res_a = f_cmd(KIND_CUBIC,
                                      f_raise(i_state.c1.x, i_state.c0.x),
                                      f_raise(i_state.c1.y, i_state.c0.y),
                                      f_raise(i_state.c1.x, mid.x),
                                      f_raise(i_state.c1.y, mid.y),
                                      f_act(mid.x), f_act(mid.y));
                        st.c0 = mid;
                        st.c1 = p;
                        st.pc = PC_TWO;
                    end else begin
                        res_a = f_cmd(KIND_CUBIC,
                                      f_act(i_state.c1.x), f_act(i_state.c1.y),
                                      f_act(i_state.c2.x), f_act(i_state.c2.y),
                                      f_act(p.x), f_act(p.y));
                        st.c0 = p;
                        st.pc = PC_ONE;
                    end
                end
                default: begin
                    // nothing pending
                    st.c1 = p;
                    if (on_curve) begin
                        has_a = 1'b1;
                        res_a = f_cmd(KIND_LINE, f_act(p.x), f_act(p.y),
                                      '0, '0, '0, '0);
                        st.c0 = p;
                        st.pc = PC_ONE;
                    end else begin
                        st.pc = PC_TWO;
                    end
                end
            endcase
        end
    end

    // contour close
    always_comb begin
        o_state = st;
        has_b   = i_item.contour_last;
        res_b   = '0;
        if (i_item.contour_last) begin
            case (st.pc)
                PC_TWO: begin
                    res_b = f_cmd(KIND_CUBIC,
                                  f_raise(st.c1.x, st.c0.x), f_raise(st.c1.y, st.c0.y),
                                  f_raise(st.c1.x, st.start.x),
                                  f_raise(st.c1.y, st.start.y),
                                  f_act(st.start.x), f_act(st.start.y));
                end
                PC_THREE: begin
                    res_b = f_cmd(KIND_CUBIC,
                                  f_act(st.c1.x), f_act(st.c1.y),
                                  f_act(st.c2.x), f_act(st.c2.y),
                                  f_act(st.start.x), f_act(st.start.y));
                end
                default: begin
                    res_b = f_cmd(KIND_CLOSE, '0, '0, '0, '0, '0, '0);
                end
            endcase
            o_state.c0 = st.start;
            o_state.pc = PC_ONE;
        end
    end

    // pack results, final one flagged
    always_comb begin
        o_push.count            = {1'b0, has_a} + {1'b0, has_b};
        o_push.res0             = has_a ? res_a : res_b;
        o_push.res0.last_of_run = !(has_a && has_b);
        o_push.res1             = res_b;
        o_push.res1.last_of_run = 1'b1;
    end

endmodule

// ----- src/ocp_result_fifo.sv -----
// ----------------------------------------------------------------------------
// ocp_result_fifo
// Small result queue: takes up to two commands a cycle, hands one a cycle
// to the command channel while the channel is ready.
// ----------------------------------------------------------------------------
module ocp_result_fifo
    import ocp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_push        i_push,
    output logic         o_room,
    ocp_cmd_if.source    o_cmd
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic                 pop;
    t_result              head;

    assign pop     = o_cmd.valid && o_cmd.ready;
    assign o_room  = r_count <= FIFO_CW'(FIFO_DEPTH - 2);
    assign n_count = r_count + FIFO_CW'(i_push.count) - FIFO_CW'(pop);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(i_push.count);
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(pop);
            r_count  <= n_count;
        end
    end

    // entry writes
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_AW'(1)] <= i_push.res1;
        end
    end

    // head of queue to the channel
    assign head              = r_mem[r_rd_ptr];
    assign o_cmd.valid       = r_count != '0;
    assign o_cmd.kind        = head.kind;
    assign o_cmd.p1_x        = head.p1_x;
    assign o_cmd.p1_y        = head.p1_y;
    assign o_cmd.p2_x        = head.p2_x;
    assign o_cmd.p2_y        = head.p2_y;
    assign o_cmd.p3_x        = head.p3_x;
    assign o_cmd.p3_y        = head.p3_y;
    assign o_cmd.last_of_run = head.last_of_run;

endmodule

// ----- src/outline_to_cubic_path.sv -----
// ----------------------------------------------------------------------------
// outline_to_cubic_path
// Converts a stream of glyph outline points into move, line, cubic and close
// path commands, in output units of one sixth of an input unit, y down.
//
// Usage:
//   i_point carries one outline point word per handshake; o_cmd carries one
//   path command word per handshake. A point gives zero, one or two
//   commands; last_of_run marks the final command a point produced.
//   Flow: a taken point waits in the input register; once the queue has
//   room for two commands it is converted and its commands enter a 4-entry
//   result queue, whose head is presented on o_cmd. The whole conversion is
//   combinational between the input register and the queue, which takes two
//   commands a cycle and gives one while o_cmd.ready is high.
//   Throughput: one point per cycle while the queue has room for two
//   commands; the second command of a contour end is absorbed by the queue.
//   Stalls: when o_cmd.ready is low the queue fills and i_point.ready drops
//   once fewer than two entries are free; nothing is lost or repeated.
//   Reset: the queue empties, the pen point and contour start go to (0,0)
//   and no points are pending.
// ----------------------------------------------------------------------------
module outline_to_cubic_path
    import ocp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ocp_point_if.sink  i_point,
    ocp_cmd_if.source  o_cmd
);

    t_item  r_in;
    logic   r_in_valid;
    t_state r_state, n_state;
    t_push  step_push, push;
    logic   room, advance, accept;

    assign advance       = r_in_valid && room;
    assign i_point.ready = !r_in_valid || advance;
    assign accept        = i_point.valid && i_point.ready;

    // input word register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.point_x       <= i_point.point_x;
            r_in.point_y       <= i_point.point_y;
            r_in.tag           <= i_point.tag;
            r_in.contour_first <= i_point.contour_first;
            r_in.contour_last  <= i_point.contour_last;
            r_in.wrap_x        <= i_point.wrap_x;
            r_in.wrap_y        <= i_point.wrap_y;
            r_in.origin_x      <= i_point.origin_x;
            r_in.origin_y      <= i_point.origin_y;
        end
    end

    // input valid and converter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= ST_RESET;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // one point converted per cycle while the queue has room
    ocp_step u_step (
        .i_item  (r_in),
        .i_state (r_state),
        .o_state (n_state),
        .o_push  (step_push)
    );

    always_comb begin
        push       = step_push;
        push.count = advance ? step_push.count : 2'd0;
    end

    // result queue toward the command channel
    ocp_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_cmd   (o_cmd)
    );

endmodule
